// ===== rtl/arrt_pkg.sv =====
`timescale 1ns / 1ps

package arrt_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned TagW  = 8;
  localparam int unsigned StatW = 3;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_MISS    = 3'd1,
    ST_FULL    = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  rend;
    logic [TagW-1:0]   tag;
    logic              hit;
    logic [TagW-1:0]   found_tag;
    logic              overlap;
  } probe_t;

endpackage

// ===== rtl/arrt_cell.sv =====
`timescale 1ns / 1ps

module arrt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  arrt_pkg::probe_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output arrt_pkg::probe_t             out_data_o,
  input  logic                         entry_valid_i,
  input  logic                         wr_en_i,
  input  logic [arrt_pkg::AddrW-1:0]   wr_start_i,
  input  logic [arrt_pkg::AddrW-1:0]   wr_limit_i,
  input  logic [arrt_pkg::TagW-1:0]    wr_tag_i
);
  import arrt_pkg::*;

  logic [AddrW-1:0] start_q;
  logic [AddrW-1:0] limit_q;
  logic [TagW-1:0]  tag_q;
  logic             valid_q;
  probe_t           data_q;
  probe_t           data_d;
  logic             contains;
  logic             collides;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  assign contains = entry_valid_i && (start_q <= in_data_i.addr) && (in_data_i.addr < limit_q);
  assign collides = entry_valid_i && (in_data_i.addr < limit_q) && (start_q < in_data_i.rend);

  always_comb begin
    data_d = in_data_i;
    if (in_data_i.cmd == CMD_LOOKUP) begin
      if (contains && !in_data_i.hit) begin
        data_d.hit       = 1'b1;
        data_d.found_tag = tag_q;
      end
    end else begin
      data_d.overlap = in_data_i.overlap || collides;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      start_q <= wr_start_i;
      limit_q <= wr_limit_i;
      tag_q   <= wr_tag_i;
    end
  end

endmodule

// ===== rtl/address_range_region_table_unit.sv =====
`timescale 1ns / 1ps
// An item passes through the cell row, one cell per entry, and then the output register.
// One item is in flight at a time: the next item is taken only after the last has walked
//   the whole cell row, and the table write of an insert lands before the next item is taken.
// A finished result waits in the output register while the next item is taken.
// Reset clears the entry count, the in-flight flag and all stage valids;
//   entry storage is not cleared.
module address_range_region_table_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // address[63:0], region_end[127:64], handler_tag[135:128]
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata    // status[2:0], found_tag[10:3], zero[15:11]
);
  import arrt_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            busy_q;
  logic [CntW-1:0] count_q;
  logic            out_valid_q;
  status_e         out_status_q;
  logic [TagW-1:0] out_tag_q;

  logic   chain_valid [ENTRIES+1];
  logic   chain_ready [ENTRIES+1];
  probe_t chain_data  [ENTRIES+1];

  logic    tail_take;
  logic    commit;
  status_e tail_status;
  logic [TagW-1:0] tail_tag;

  assign s_axis_tready  = !busy_q && chain_ready[0];
  assign chain_valid[0] = s_axis_tvalid && !busy_q;

  always_comb begin
    chain_data[0]           = '0;
    chain_data[0].cmd       = cmd_e'(s_axis_tuser);
    chain_data[0].addr      = s_axis_tdata[63:0];
    chain_data[0].rend      = s_axis_tdata[127:64];
    chain_data[0].tag       = s_axis_tdata[135:128];
  end

  assign chain_ready[ENTRIES] = !out_valid_q || m_axis_tready;
  assign tail_take            = chain_valid[ENTRIES] && chain_ready[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arrt_cell u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i    (chain_valid[i]),
      .in_ready_o    (chain_ready[i]),
      .in_data_i     (chain_data[i]),
      .out_valid_o   (chain_valid[i+1]),
      .out_ready_i   (chain_ready[i+1]),
      .out_data_o    (chain_data[i+1]),
      .entry_valid_i (count_q > CntW'(i)),
      .wr_en_i       (tail_take && commit && (count_q[IdxW-1:0] == IdxW'(i))),
      .wr_start_i    (chain_data[ENTRIES].addr),
      .wr_limit_i    (chain_data[ENTRIES].rend),
      .wr_tag_i      (chain_data[ENTRIES].tag)
    );
  end

  always_comb begin
    commit      = 1'b0;
    tail_tag    = '0;
    tail_status = ST_OK;
    if (chain_data[ENTRIES].cmd == CMD_LOOKUP) begin
      if (chain_data[ENTRIES].hit) begin
        tail_tag = chain_data[ENTRIES].found_tag;
      end else begin
        tail_status = ST_MISS;
      end
    end else if (chain_data[ENTRIES].addr >= chain_data[ENTRIES].rend) begin
      tail_status = ST_EMPTY;
    end else if (chain_data[ENTRIES].overlap) begin
      tail_status = ST_OVERLAP;
    end else if (count_q == CntW'(ENTRIES)) begin
      tail_status = ST_FULL;
    end else begin
      commit = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        busy_q <= 1'b1;
      end else if (tail_take) begin
        busy_q <= 1'b0;
      end
      if (tail_take && commit) begin
        count_q <= count_q + CntW'(1);
      end
      if (tail_take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_take) begin
      out_status_q <= tail_status;
      out_tag_q    <= tail_tag;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_tag_q, out_status_q};

endmodule
